// ===== rtl/core/kcd_pkg.sv =====
package kcd_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int MAX_ENTRIES = 4096;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = ENTRY_W + 1;
   localparam int CFG_W       = NODE_W + 1;
   localparam int BKT_DEPTH   = MAX_ENTRIES + 1;
   localparam int BKT_W       = $clog2(BKT_DEPTH);
   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(MAX_NODES);

   localparam int STATE_W = 5;
   localparam logic [STATE_W-1:0] ST_IDLE    = 5'd0;
   localparam logic [STATE_W-1:0] ST_CLRDEG  = 5'd1;
   localparam logic [STATE_W-1:0] ST_DEG_A   = 5'd2;
   localparam logic [STATE_W-1:0] ST_DEG_B   = 5'd3;
   localparam logic [STATE_W-1:0] ST_DEG_C   = 5'd4;
   localparam logic [STATE_W-1:0] ST_OFF_A   = 5'd5;
   localparam logic [STATE_W-1:0] ST_OFF_B   = 5'd6;
   localparam logic [STATE_W-1:0] ST_FILL_A  = 5'd7;
   localparam logic [STATE_W-1:0] ST_FILL_B  = 5'd8;
   localparam logic [STATE_W-1:0] ST_FILL_C  = 5'd9;
   localparam logic [STATE_W-1:0] ST_BCLR    = 5'd10;
   localparam logic [STATE_W-1:0] ST_BCNT_A  = 5'd11;
   localparam logic [STATE_W-1:0] ST_BCNT_B  = 5'd12;
   localparam logic [STATE_W-1:0] ST_BCNT_C  = 5'd13;
   localparam logic [STATE_W-1:0] ST_BSCAN_A = 5'd14;
   localparam logic [STATE_W-1:0] ST_BSCAN_B = 5'd15;
   localparam logic [STATE_W-1:0] ST_PLACE_A = 5'd16;
   localparam logic [STATE_W-1:0] ST_PLACE_B = 5'd17;
   localparam logic [STATE_W-1:0] ST_PLACE_C = 5'd18;
   localparam logic [STATE_W-1:0] ST_SHIFT_A = 5'd19;
   localparam logic [STATE_W-1:0] ST_SHIFT_B = 5'd20;
   localparam logic [STATE_W-1:0] ST_PEEL_U  = 5'd21;
   localparam logic [STATE_W-1:0] ST_PEEL_D  = 5'd22;
   localparam logic [STATE_W-1:0] ST_PEEL_L  = 5'd23;
   localparam logic [STATE_W-1:0] ST_PEEL_J  = 5'd24;
   localparam logic [STATE_W-1:0] ST_PEEL_W  = 5'd25;
   localparam logic [STATE_W-1:0] ST_PEEL_X  = 5'd26;
   localparam logic [STATE_W-1:0] ST_PEEL_F  = 5'd27;
   localparam logic [STATE_W-1:0] ST_PEEL_S1 = 5'd28;
   localparam logic [STATE_W-1:0] ST_PEEL_S2 = 5'd29;
   localparam logic [STATE_W-1:0] ST_PEEL_C  = 5'd30;

   localparam logic KIND_EDGE  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic               load;
      logic               query;
      logic               q_load;
   } kcd_cmd_type;

   typedef struct packed {
      logic loop_end;
      logic nbr_higher;
   } kcd_status_type;

endpackage

// ===== rtl/core/core_number_decomposition_top.sv =====
// k-core decomposition engine. Kind-0 transactions load adjacency entries, one per
// cycle while req_stall is low, into an entry store of MAX_ENTRIES; self-loops are
// skipped, and entries that name a node at or above node_count or overflow the store
// are dropped and flagged. The entry marked last starts a run that computes every
// node's core number by bucket peeling over memories with one read and one write port
// each; req_stall stays high for the whole run. A kind-1 transaction reads the
// core-number memory on acceptance; a pending register then loads the read result
// into the registered response and raises rsp_valid. An edge after a finished run
// begins a new graph. No clearing pass after reset: core numbers read as zero until
// the first run completes.
module core_number_decomposition_top import kcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [NODE_W-1:0] req_edge_source,
   input  logic [NODE_W-1:0] req_edge_target,
   input  logic              req_last_edge,
   input  logic [NODE_W-1:0] req_query_node,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CNT_W-1:0]  rsp_core_number,
   output logic              rsp_node_out_of_range,
   output logic              rsp_entries_dropped,
   // node_count register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_node_count
);

   kcd_cmd_type    cmd;
   kcd_status_type status;

   // the user must make register writes only while idle; the block does not enforce it, and the port always takes them
   assign csr_ready = 1'b1;

   // sequencer: handshakes and the run phases
   kcd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_kind      (req_kind),
      .req_last_edge (req_last_edge),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // memories, loop counters and the response payload
   kcd_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_edge_source       (req_edge_source),
      .req_edge_target       (req_edge_target),
      .req_last_edge         (req_last_edge),
      .req_query_node        (req_query_node),
      .csr_write             (csr_valid & csr_ready),
      .csr_node_count        (csr_node_count),
      .rsp_core_number       (rsp_core_number),
      .rsp_node_out_of_range (rsp_node_out_of_range),
      .rsp_entries_dropped   (rsp_entries_dropped)
   );

endmodule

// ===== rtl/core/kcd_ram.sv =====
module kcd_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kcd_ctrl.sv =====
module kcd_ctrl import kcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_kind,
   input  logic           req_last_edge,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  kcd_status_type status,
   output kcd_cmd_type    cmd
);

   logic [STATE_W-1:0] state_ff, state_in;
   logic               q_pend_ff, q_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   assign req_stall = (state_ff != ST_IDLE) | q_pend_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.state  = state_ff;
      cmd.load   = accept & (req_kind == KIND_EDGE);
      cmd.query  = accept & (req_kind == KIND_QUERY);
      cmd.q_load = q_pend_ff;
   end

   always_comb begin
      q_pend_in    = cmd.query;
      rsp_valid_in = q_pend_ff | (rsp_valid_ff & rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (cmd.load && req_last_edge) state_in = ST_CLRDEG;
         ST_CLRDEG:  if (status.loop_end) state_in = ST_DEG_A;
         ST_DEG_A:   state_in = status.loop_end ? ST_OFF_A : ST_DEG_B;
         ST_DEG_B:   state_in = ST_DEG_C;
         ST_DEG_C:   state_in = ST_DEG_A;
         ST_OFF_A:   state_in = status.loop_end ? ST_FILL_A : ST_OFF_B;
         ST_OFF_B:   state_in = ST_OFF_A;
         ST_FILL_A:  state_in = status.loop_end ? ST_BCLR : ST_FILL_B;
         ST_FILL_B:  state_in = ST_FILL_C;
         ST_FILL_C:  state_in = ST_FILL_A;
         ST_BCLR:    if (status.loop_end) state_in = ST_BCNT_A;
         ST_BCNT_A:  state_in = status.loop_end ? ST_BSCAN_A : ST_BCNT_B;
         ST_BCNT_B:  state_in = ST_BCNT_C;
         ST_BCNT_C:  state_in = ST_BCNT_A;
         ST_BSCAN_A: state_in = status.loop_end ? ST_PLACE_A : ST_BSCAN_B;
         ST_BSCAN_B: state_in = ST_BSCAN_A;
         ST_PLACE_A: state_in = status.loop_end ? ST_SHIFT_A : ST_PLACE_B;
         ST_PLACE_B: state_in = ST_PLACE_C;
         ST_PLACE_C: state_in = ST_PLACE_A;
         ST_SHIFT_A: state_in = status.loop_end ? ST_PEEL_U : ST_SHIFT_B;
         ST_SHIFT_B: state_in = ST_SHIFT_A;
         ST_PEEL_U:  state_in = status.loop_end ? ST_IDLE : ST_PEEL_D;
         ST_PEEL_D:  state_in = ST_PEEL_L;
         ST_PEEL_L:  state_in = ST_PEEL_J;
         ST_PEEL_J:  state_in = status.loop_end ? ST_PEEL_C : ST_PEEL_W;
         ST_PEEL_W:  state_in = ST_PEEL_X;
         ST_PEEL_X:  state_in = status.nbr_higher ? ST_PEEL_F : ST_PEEL_J;
         ST_PEEL_F:  state_in = ST_PEEL_S1;
         ST_PEEL_S1: state_in = ST_PEEL_S2;
         ST_PEEL_S2: state_in = ST_PEEL_J;
         ST_PEEL_C:  state_in = ST_PEEL_U;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_pend_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_pend_ff    <= q_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while the run is busy");

   a_query_result: assert property (@(posedge clock) disable iff (reset)
      q_pend_ff |=> rsp_valid_ff)
      else $error("query read did not produce a result");

   a_query_idle: assert property (@(posedge clock) disable iff (reset)
      q_pend_ff |-> (state_ff == ST_IDLE) && !$past(state_ff != ST_IDLE))
      else $error("query pending during a run");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && req_last_edge) |=> (state_ff == ST_CLRDEG))
      else $error("last entry did not start the run");

endmodule

// ===== rtl/core/kcd_dp.sv =====
module kcd_dp import kcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  kcd_cmd_type         cmd,
   output kcd_status_type      status,
   input  logic [NODE_W-1:0]   req_edge_source,
   input  logic [NODE_W-1:0]   req_edge_target,
   input  logic                req_last_edge,
   input  logic [NODE_W-1:0]   req_query_node,
   input  logic                csr_write,
   input  logic [CFG_W-1:0]    csr_node_count,
   output logic [CNT_W-1:0]    rsp_core_number,
   output logic                rsp_node_out_of_range,
   output logic                rsp_entries_dropped
);

   // control registers
   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             drop_ff, drop_in;
   logic             done_ff, done_in;
   logic             ran_ff, ran_in;
   logic [CFG_W-1:0] nrun_ff, nrun_in;
   // run registers
   logic [CFG_W-1:0]  nn_ff, nn_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  top_ff, top_in;
   logic [CNT_W-1:0]  a_ff, a_in;
   logic              ok_ff, ok_in;
   logic [NODE_W-1:0] s_ff, s_in;
   logic [NODE_W-1:0] t_ff, t_in;
   logic [NODE_W-1:0] u_ff, u_in;
   logic [CNT_W-1:0]  du_ff, du_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  jhi_ff, jhi_in;
   logic [NODE_W-1:0] w_ff, w_in;
   logic [CNT_W-1:0]  dw_ff, dw_in;
   logic [CNT_W-1:0]  pw_ff, pw_in;
   logic [CNT_W-1:0]  pf_ff, pf_in;
   logic [NODE_W-1:0] x_ff, x_in;
   // query registers
   logic              qz_ff, qz_in;
   logic              qoor_ff, qoor_in;
   logic              qdrop_ff, qdrop_in;
   logic [CNT_W-1:0]  core_ff, core_in;
   logic              oor_ff, oor_in;
   logic              dropo_ff, dropo_in;

   // memory ports
   logic               ent_we;
   logic [ENTRY_W-1:0] ent_wa, ent_ra;
   logic [NODE_W-1:0]  src_rd, tgt_rd;
   logic               deg_we;
   logic [NODE_W-1:0]  deg_wa, deg_ra;
   logic [CNT_W-1:0]   deg_wd, deg_rd;
   logic               pos_we;
   logic [NODE_W-1:0]  pos_wa, pos_ra;
   logic [CNT_W-1:0]   pos_wd, pos_rd;
   logic               nbr_we;
   logic [ENTRY_W-1:0] nbr_wa, nbr_ra;
   logic [NODE_W-1:0]  nbr_wd, nbr_rd;
   logic               off_we;
   logic [NODE_W-1:0]  off_wa, off_ra;
   logic [2*CNT_W-1:0] off_wd, off_rd;
   logic               bkt_we;
   logic [BKT_W-1:0]   bkt_wa, bkt_ra;
   logic [CNT_W-1:0]   bkt_wd, bkt_rd;
   logic               ord_we;
   logic [NODE_W-1:0]  ord_wa, ord_ra;
   logic [NODE_W-1:0]  ord_wd, ord_rd;
   logic               core_we;
   logic [NODE_W-1:0]  core_wa, core_ra;
   logic [CNT_W-1:0]   core_wd, core_rd;

   logic [CFG_W-1:0] nuse;
   logic [CNT_W-1:0] cnt_eff;
   logic             drop_eff;
   logic             ent_ok;
   logic             lend;
   logic [CNT_W-1:0] nn_ext;

   assign nuse     = (cfg_ff > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : cfg_ff;
   assign cnt_eff  = done_ff ? '0 : cnt_ff;
   assign drop_eff = done_ff ? 1'b0 : drop_ff;
   assign nn_ext   = CNT_W'(nn_ff);
   assign ent_ok   = ({1'b0, src_rd} < nn_ff) && ({1'b0, tgt_rd} < nn_ff) && (src_rd != tgt_rd);

   always_comb begin
      case (cmd.state)
         ST_CLRDEG, ST_OFF_A, ST_BCNT_A, ST_PLACE_A, ST_PEEL_U: lend = (idx_ff == nn_ext);
         ST_DEG_A, ST_FILL_A:   lend = (idx_ff == cnt_ff);
         ST_BCLR, ST_BSCAN_A:   lend = (idx_ff > top_ff);
         ST_SHIFT_A:            lend = (idx_ff == '0);
         ST_PEEL_J:             lend = (j_ff == jhi_ff);
         default:               lend = 1'b0;
      endcase
      status.loop_end   = lend;
      status.nbr_higher = (deg_rd > du_ff);
   end

   always_comb begin
      cfg_in   = csr_write ? csr_node_count : cfg_ff;
      cnt_in   = cnt_ff;   drop_in = drop_ff;  done_in = done_ff;
      ran_in   = ran_ff;   nrun_in = nrun_ff;  nn_in   = nn_ff;
      idx_in   = idx_ff;   acc_in  = acc_ff;   top_in  = top_ff;
      a_in     = a_ff;     ok_in   = ok_ff;    s_in    = s_ff;    t_in = t_ff;
      u_in     = u_ff;     du_in   = du_ff;    j_in    = j_ff;    jhi_in = jhi_ff;
      w_in     = w_ff;     dw_in   = dw_ff;    pw_in   = pw_ff;   pf_in = pf_ff;
      x_in     = x_ff;
      qz_in    = qz_ff;    qoor_in = qoor_ff;  qdrop_in = qdrop_ff;
      core_in  = core_ff;  oor_in  = oor_ff;   dropo_in = dropo_ff;

      ent_we = 1'b0; ent_wa = cnt_eff[ENTRY_W-1:0]; ent_ra = idx_ff[ENTRY_W-1:0];
      deg_we = 1'b0; deg_wa = idx_ff[NODE_W-1:0];   deg_wd = '0;  deg_ra = idx_ff[NODE_W-1:0];
      pos_we = 1'b0; pos_wa = idx_ff[NODE_W-1:0];   pos_wd = acc_ff; pos_ra = src_rd;
      nbr_we = 1'b0; nbr_wa = pos_rd[ENTRY_W-1:0];  nbr_wd = t_ff; nbr_ra = j_ff[ENTRY_W-1:0];
      off_we = 1'b0; off_wa = idx_ff[NODE_W-1:0];   off_wd = '0;  off_ra = ord_rd;
      bkt_we = 1'b0; bkt_wa = idx_ff[BKT_W-1:0];    bkt_wd = '0;  bkt_ra = idx_ff[BKT_W-1:0];
      ord_we = 1'b0; ord_wa = bkt_rd[NODE_W-1:0];   ord_wd = idx_ff[NODE_W-1:0];
      ord_ra = idx_ff[NODE_W-1:0];
      core_we = 1'b0; core_wa = u_ff; core_wd = du_ff; core_ra = req_query_node;

      if (cmd.q_load) begin
         core_in  = qz_ff ? '0 : core_rd;
         oor_in   = qoor_ff;
         dropo_in = qdrop_ff;
      end

      case (cmd.state)
         ST_IDLE: begin
            if (cmd.query) begin
               qoor_in  = ({1'b0, req_query_node} >= nuse);
               qz_in    = ({1'b0, req_query_node} >= nuse) || !ran_ff ||
                          ({1'b0, req_query_node} >= nrun_ff);
               qdrop_in = drop_ff;
            end
            if (cmd.load) begin
               cnt_in  = cnt_eff;
               drop_in = drop_eff;
               done_in = 1'b0;
               if (req_edge_source != req_edge_target) begin
                  if (({1'b0, req_edge_source} >= nuse) || ({1'b0, req_edge_target} >= nuse) ||
                      cnt_eff[CNT_W-1]) begin
                     drop_in = 1'b1;
                  end else begin
                     ent_we = 1'b1;
                     cnt_in = cnt_eff + 1'b1;
                  end
               end
               if (req_last_edge) begin
                  nn_in  = nuse;
                  idx_in = '0;
                  acc_in = '0;
                  top_in = '0;
               end
            end
         end
         ST_CLRDEG: begin
            if (lend) idx_in = '0;
            else begin
               deg_we = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DEG_A:   if (lend) idx_in = '0;
         ST_DEG_B: begin
            ok_in  = ent_ok;
            s_in   = src_rd;
            deg_ra = src_rd;
         end
         ST_DEG_C: begin
            deg_we = ok_ff;
            deg_wa = s_ff;
            deg_wd = deg_rd + 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_OFF_A: begin
            if (lend) begin
               idx_in = '0;
               acc_in = '0;
            end
         end
         ST_OFF_B: begin
            off_we = 1'b1;
            off_wd = {acc_ff, acc_ff + deg_rd};
            pos_we = 1'b1;
            acc_in = acc_ff + deg_rd;
            if (deg_rd > top_ff) top_in = deg_rd;
            idx_in = idx_ff + 1'b1;
         end
         ST_FILL_A:  if (lend) idx_in = '0;
         ST_FILL_B: begin
            ok_in  = ent_ok;
            s_in   = src_rd;
            t_in   = tgt_rd;
            pos_ra = src_rd;
         end
         ST_FILL_C: begin
            nbr_we = ok_ff;
            pos_we = ok_ff;
            pos_wa = s_ff;
            pos_wd = pos_rd + 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_BCLR: begin
            if (lend) idx_in = '0;
            else begin
               bkt_we = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_BCNT_A:  if (lend) idx_in = '0;
         ST_BCNT_B: begin
            a_in   = deg_rd;
            bkt_ra = deg_rd[BKT_W-1:0];
         end
         ST_BCNT_C: begin
            bkt_we = 1'b1;
            bkt_wa = a_ff[BKT_W-1:0];
            bkt_wd = bkt_rd + 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_BSCAN_A: if (lend) idx_in = '0;
         ST_BSCAN_B: begin
            bkt_we = 1'b1;
            bkt_wd = acc_ff;
            acc_in = acc_ff + bkt_rd;
            idx_in = idx_ff + 1'b1;
         end
         ST_PLACE_A: if (lend) idx_in = top_ff;
         ST_PLACE_B: begin
            a_in   = deg_rd;
            bkt_ra = deg_rd[BKT_W-1:0];
         end
         ST_PLACE_C: begin
            bkt_we = 1'b1;
            bkt_wa = a_ff[BKT_W-1:0];
            bkt_wd = bkt_rd + 1'b1;
            pos_we = 1'b1;
            pos_wd = bkt_rd;
            ord_we = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_SHIFT_A: begin
            if (lend) bkt_we = 1'b1;
            else bkt_ra = BKT_W'(idx_ff - 1'b1);
         end
         ST_SHIFT_B: begin
            bkt_we = 1'b1;
            bkt_wd = bkt_rd;
            idx_in = idx_ff - 1'b1;
         end
         ST_PEEL_U: begin
            if (lend) begin
               done_in = 1'b1;
               ran_in  = 1'b1;
               nrun_in = nn_ff;
            end
         end
         ST_PEEL_D: begin
            u_in   = ord_rd;
            deg_ra = ord_rd;
         end
         ST_PEEL_L: begin
            du_in  = deg_rd;
            j_in   = off_rd[2*CNT_W-1:CNT_W];
            jhi_in = off_rd[CNT_W-1:0];
         end
         ST_PEEL_W: begin
            w_in   = nbr_rd;
            deg_ra = nbr_rd;
            pos_ra = nbr_rd;
         end
         ST_PEEL_X: begin
            dw_in  = deg_rd;
            pw_in  = pos_rd;
            bkt_ra = deg_rd[BKT_W-1:0];
            if (!(deg_rd > du_ff)) j_in = j_ff + 1'b1;
         end
         ST_PEEL_F: begin
            pf_in  = bkt_rd;
            ord_ra = bkt_rd[NODE_W-1:0];
         end
         ST_PEEL_S1: begin
            // neighbour moves to the front of its bucket, bucket shrinks by one
            x_in   = ord_rd;
            ord_we = 1'b1;
            ord_wa = pf_ff[NODE_W-1:0];
            ord_wd = w_ff;
            pos_we = 1'b1;
            pos_wa = w_ff;
            pos_wd = pf_ff;
            bkt_we = 1'b1;
            bkt_wa = dw_ff[BKT_W-1:0];
            bkt_wd = pf_ff + 1'b1;
            deg_we = 1'b1;
            deg_wa = w_ff;
            deg_wd = dw_ff - 1'b1;
         end
         ST_PEEL_S2: begin
            ord_we = 1'b1;
            ord_wa = pw_ff[NODE_W-1:0];
            ord_wd = x_ff;
            pos_we = 1'b1;
            pos_wa = x_ff;
            pos_wd = pw_ff;
            j_in   = j_ff + 1'b1;
         end
         ST_PEEL_C: begin
            core_we = 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= NODE_COUNT_RESET;
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
         done_ff <= 1'b0;
         ran_ff  <= 1'b0;
         nrun_ff <= '0;
      end else begin
         cfg_ff  <= cfg_in;
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
         done_ff <= done_in;
         ran_ff  <= ran_in;
         nrun_ff <= nrun_in;
      end
   end

   always_ff @(posedge clock) begin
      nn_ff  <= nn_in;   idx_ff <= idx_in;  acc_ff <= acc_in;  top_ff <= top_in;
      a_ff   <= a_in;    ok_ff  <= ok_in;   s_ff   <= s_in;    t_ff   <= t_in;
      u_ff   <= u_in;    du_ff  <= du_in;   j_ff   <= j_in;    jhi_ff <= jhi_in;
      w_ff   <= w_in;    dw_ff  <= dw_in;   pw_ff  <= pw_in;   pf_ff  <= pf_in;
      x_ff   <= x_in;
      qz_ff  <= qz_in;   qoor_ff <= qoor_in; qdrop_ff <= qdrop_in;
      core_ff <= core_in; oor_ff <= oor_in;  dropo_ff <= dropo_in;
   end

   assign rsp_core_number       = core_ff;
   assign rsp_node_out_of_range = oor_ff;
   assign rsp_entries_dropped   = dropo_ff;

   kcd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_src (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(req_edge_source),
      .rd_addr(ent_ra), .rd_data(src_rd));
   kcd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_tgt (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(req_edge_target),
      .rd_addr(ent_ra), .rd_data(tgt_rd));
   kcd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_deg (
      .clock(clock), .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
      .rd_addr(deg_ra), .rd_data(deg_rd));
   kcd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_pos (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_wa), .wr_data(pos_wd),
      .rd_addr(pos_ra), .rd_data(pos_rd));
   kcd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_nbr (
      .clock(clock), .wr_en(nbr_we), .wr_addr(nbr_wa), .wr_data(nbr_wd),
      .rd_addr(nbr_ra), .rd_data(nbr_rd));
   kcd_ram #(.WIDTH(2*CNT_W), .DEPTH(MAX_NODES)) u_off (
      .clock(clock), .wr_en(off_we), .wr_addr(off_wa), .wr_data(off_wd),
      .rd_addr(off_ra), .rd_data(off_rd));
   kcd_ram #(.WIDTH(CNT_W), .DEPTH(BKT_DEPTH)) u_bkt (
      .clock(clock), .wr_en(bkt_we), .wr_addr(bkt_wa), .wr_data(bkt_wd),
      .rd_addr(bkt_ra), .rd_data(bkt_rd));
   kcd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ord (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_addr(ord_ra), .rd_data(ord_rd));
   kcd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_core (
      .clock(clock), .wr_en(core_we), .wr_addr(core_wa), .wr_data(core_wd),
      .rd_addr(core_ra), .rd_data(core_rd));

endmodule
